// ----- sv/system_timer_compare_channels_assert.svh -----
// Assertion helpers for the system timer; each expects clk and rst in scope.
`ifndef SYSTEM_TIMER_COMPARE_CHANNELS_ASSERT_SVH
`define SYSTEM_TIMER_COMPARE_CHANNELS_ASSERT_SVH

// Same-cycle implication.
`define STC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("system timer check failed");

// Next-cycle implication.
`define STC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("system timer check failed");

`endif

// ----- sv/stc_pkg.sv -----
package stc_pkg;

  localparam int NUM_CHANNELS = 4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [7:0] ADDR_CTRL  = 8'd0;
  localparam logic [7:0] ADDR_COUNT = 8'd1;
  localparam logic [7:0] CHAN_BASE  = 8'd4;

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_FLAG    = 2'd1;
  localparam logic [1:0] REG_COMPARE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  word_addr;
    logic [3:0]  byte_enable;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } rsp_t;

  typedef struct packed {
    logic        irq;
    logic        counting;
    logic [31:0] count;
  } status_t;

endpackage

// ----- sv/stc_in_stage.sv -----
module stc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  stc_pkg::req_t req,
  input  logic          go,
  output logic          held,
  output stc_pkg::req_t item
);
  import stc_pkg::*;

  // Take a new word whenever the slot is empty or drains this cycle.
  assign req_ready = !held || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req_ready) begin
      held <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

endmodule

// ----- sv/stc_core.sv -----
module stc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  stc_pkg::req_t    item,
  output stc_pkg::rsp_t    result,
  output stc_pkg::status_t status
);
  import stc_pkg::*;

  logic                    count_enable, count_enable_next;
  logic                    freeze_bit, freeze_bit_next;
  logic [7:0]              prescale_code, prescale_code_next;
  logic [7:0]              prescale_phase, prescale_phase_next;
  logic [31:0]             counter_value, counter_value_next;
  logic [NUM_CHANNELS-1:0] chan_enable, chan_enable_next;
  logic [NUM_CHANNELS-1:0] chan_flag, chan_flag_next;
  logic [31:0]             chan_compare [NUM_CHANNELS];
  logic [31:0]             chan_compare_next [NUM_CHANNELS];

  logic [31:0]             mask;
  logic [31:0]             ctrl_word;
  logic [31:0]             ctrl_merge;
  logic [31:0]             counter_inc;
  logic [7:0]              rel;
  logic                    chan_hit;
  logic [NUM_CHANNELS-1:0] chan_sel;
  logic [31:0]             rd;

  assign mask = {{8{item.byte_enable[3]}}, {8{item.byte_enable[2]}},
                 {8{item.byte_enable[1]}}, {8{item.byte_enable[0]}}};
  assign ctrl_word   = {16'd0, prescale_code, 6'd0, freeze_bit, count_enable};
  assign ctrl_merge  = (ctrl_word & ~mask) | (item.write_data & mask);
  assign counter_inc = counter_value + 32'd1;

  // Channel c register k lives at word CHAN_BASE + 4c + k; slot 3 is a hole.
  assign rel      = item.word_addr - CHAN_BASE;
  assign chan_hit = (item.word_addr >= CHAN_BASE) && (rel[1:0] != 2'd3);

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_sel[c] = chan_hit && (rel[7:2] == 6'(c));
    end
  end

  always_comb begin
    count_enable_next   = count_enable;
    freeze_bit_next     = freeze_bit;
    prescale_code_next  = prescale_code;
    prescale_phase_next = prescale_phase;
    counter_value_next  = counter_value;
    chan_enable_next    = chan_enable;
    chan_flag_next      = chan_flag;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_compare_next[c] = chan_compare[c];
    end

    if (item.op == OP_TICK && count_enable) begin
      if (prescale_phase < prescale_code) begin
        prescale_phase_next = prescale_phase + 8'd1;
      end else begin
        prescale_phase_next = 8'd0;
        counter_value_next  = counter_inc;
        // Flag only on a step onto the compare value.
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (chan_enable[c] && !chan_flag[c] && counter_inc == chan_compare[c]) begin
            chan_flag_next[c] = 1'b1;
          end
        end
      end
    end else if (item.op == OP_WRITE && (|item.byte_enable)) begin
      if (item.word_addr == ADDR_CTRL) begin
        count_enable_next   = ctrl_merge[0];
        freeze_bit_next     = ctrl_merge[1];
        prescale_code_next  = ctrl_merge[15:8];
        prescale_phase_next = 8'd0;
      end else if (item.word_addr == ADDR_COUNT) begin
        counter_value_next  = (counter_value & ~mask) | (item.write_data & mask);
        prescale_phase_next = 8'd0;
      end else begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (chan_sel[c]) begin
            case (rel[1:0])
              REG_ENABLE: begin
                if (item.byte_enable[0]) begin
                  chan_enable_next[c] = item.write_data[0];
                end
              end
              REG_FLAG: begin
                // Write one to clear, lane 0 only.
                if (item.byte_enable[0] && item.write_data[0]) begin
                  chan_flag_next[c] = 1'b0;
                end
              end
              REG_COMPARE: begin
                chan_compare_next[c] = (chan_compare[c] & ~mask) |
                                       (item.write_data & mask);
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    rd = 32'd0;
    if (item.op == OP_READ) begin
      if (item.word_addr == ADDR_CTRL) begin
        rd = ctrl_word;
      end else if (item.word_addr == ADDR_COUNT) begin
        rd = counter_value;
      end else begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (chan_sel[c]) begin
            case (rel[1:0])
              REG_ENABLE:  rd = {31'd0, chan_enable[c]};
              REG_FLAG:    rd = {31'd0, chan_flag[c]};
              REG_COMPARE: rd = chan_compare[c];
              default:     rd = 32'd0;
            endcase
          end
        end
      end
    end
  end

  assign result.read_data = rd;
  assign result.irq       = |(chan_enable_next & chan_flag_next);

  assign status.irq      = |(chan_enable & chan_flag);
  assign status.counting = count_enable;
  assign status.count    = counter_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_enable   <= 1'b0;
      freeze_bit     <= 1'b0;
      prescale_code  <= 8'd0;
      prescale_phase <= 8'd0;
      counter_value  <= 32'd0;
      chan_enable    <= '0;
      chan_flag      <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_compare[c] <= 32'd0;
      end
    end else if (go) begin
      count_enable   <= count_enable_next;
      freeze_bit     <= freeze_bit_next;
      prescale_code  <= prescale_code_next;
      prescale_phase <= prescale_phase_next;
      counter_value  <= counter_value_next;
      chan_enable    <= chan_enable_next;
      chan_flag      <= chan_flag_next;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_compare[c] <= chan_compare_next[c];
      end
    end
  end

endmodule

// ----- sv/system_timer_compare_channels.sv -----
// System timer: 32-bit counter with prescaler and compare channels, driven by
// one request word per module clock while the response side is not stalled
// (tick, register read or byte-enabled register write). Each request yields
// exactly one response word carrying the read data and the interrupt level
// after that request. Throughput is one word per cycle while rsp_ready stays
// high. The request register feeds a combinational state update straight into
// the response register, and a stall can hold a word in the request register.
// A stalled response holds back only the request stage behind it.
module system_timer_compare_channels (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  stc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output stc_pkg::rsp_t rsp
);
  import stc_pkg::*;

  `include "system_timer_compare_channels_assert.svh"

  logic    held;
  logic    go;
  req_t    item;
  rsp_t    result;
  status_t status;

  // Advance the held word when the response register is free or draining.
  assign go = held && (!rsp_valid || rsp_ready);

  stc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .go        (go),
    .held      (held),
    .item      (item)
  );

  stc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (item),
    .result (result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp <= result;
    end
  end

  `STC_ASSERT_NEXT(a_go_gives_rsp, go, rsp_valid)
  `STC_ASSERT_NEXT(a_irq_matches_state, go, rsp.irq == status.irq)
  `STC_ASSERT_NEXT(a_held_not_dropped, held && !go, held)
  `STC_ASSERT_NEXT(a_stopped_count_holds, go && item.op == OP_TICK && !status.counting,
                   $stable(status.count))

endmodule

// ----- sim/tb_system_timer_compare_channels.sv -----
module tb_system_timer_compare_channels;
  import stc_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [7:0] ADDR_GAP   = 8'd2;
  localparam logic [7:0] ADDR_TOP   = 8'hFF;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int WORDS_PER_PHASE = 280;
  localparam int HOLD_CYCLES   = 300;

  // Shadow of the timer registers plus the queue of responses it predicts.
  class timer_shadow;
    bit          cnt_en;
    bit          frz;
    bit [7:0]    presc;
    bit [7:0]    phase;
    bit [31:0]   counter;
    bit          ch_en   [NUM_CHANNELS];
    bit          ch_flag [NUM_CHANNELS];
    bit [31:0]   ch_cmp  [NUM_CHANNELS];
    rsp_t        due_rsp [$];
    int          errors;

    function bit [31:0] ctrl_word();
      return {16'h0, presc, 6'h0, frz, cnt_en};
    endfunction

    function bit chan_reg(bit [7:0] addr, output int ch, output bit [1:0] k);
      bit [7:0] rel;
      ch = 0;
      k = REG_UNUSED;
      if (addr < CHAN_BASE) return 1'b0;
      rel = addr - CHAN_BASE;
      ch = int'(rel >> 2);
      k = rel[1:0];
      return (ch < NUM_CHANNELS) && (k != REG_UNUSED);
    endfunction

    function void advance();
      if (!cnt_en) return;
      if (phase < presc) begin
        phase++;
        return;
      end
      phase = '0;
      counter++;
      foreach (ch_en[c])
        if (ch_en[c] && !ch_flag[c] && counter == ch_cmp[c]) ch_flag[c] = 1'b1;
    endfunction

    function bit [31:0] read_reg(bit [7:0] addr);
      int ch;
      bit [1:0] k;
      if (addr == ADDR_CTRL) return ctrl_word();
      if (addr == ADDR_COUNT) return counter;
      if (!chan_reg(addr, ch, k)) return '0;
      case (k)
        REG_ENABLE: return 32'(ch_en[ch]);
        REG_FLAG:   return 32'(ch_flag[ch]);
        default:    return ch_cmp[ch];
      endcase
    endfunction

    function void write_reg(bit [7:0] addr, bit [3:0] be, bit [31:0] data);
      bit [31:0] m;
      bit [31:0] nxt;
      int ch;
      bit [1:0] k;
      m = '0;
      foreach (be[i]) if (be[i]) m[8*i +: 8] = 8'hFF;
      if (m == '0) return;
      if (addr == ADDR_CTRL) begin
        nxt = (ctrl_word() & ~m) | (data & m);
        cnt_en = nxt[0];
        frz = nxt[1];
        presc = nxt[15:8];
        phase = '0;
        return;
      end
      if (addr == ADDR_COUNT) begin
        counter = (counter & ~m) | (data & m);
        phase = '0;
        return;
      end
      if (!chan_reg(addr, ch, k)) return;
      case (k)
        REG_ENABLE: if (be[0]) ch_en[ch] = data[0];
        // only an explicit 1 on lane 0 clears; nothing here ever sets
        REG_FLAG:   if (be[0] && data[0]) ch_flag[ch] = 1'b0;
        default:    ch_cmp[ch] = (ch_cmp[ch] & ~m) | (data & m);
      endcase
    endfunction

    function void take_request(req_t r);
      rsp_t e;
      e = '0;
      case (r.op)
        OP_TICK:  advance();
        OP_READ:  e.read_data = read_reg(r.word_addr);
        OP_WRITE: write_reg(r.word_addr, r.byte_enable, r.write_data);
        default: ;
      endcase
      foreach (ch_en[c]) if (ch_en[c] && ch_flag[c]) e.irq = 1'b1;
      due_rsp.push_back(e);
    endfunction

    function void match_response(rsp_t got);
      rsp_t e;
      if (due_rsp.size() == 0) begin
        if (errors < 10)
          $display("unexpected response word: read_data=%h irq=%b", got.read_data, got.irq);
        errors++;
        return;
      end
      e = due_rsp.pop_front();
      if (got.read_data !== e.read_data || got.irq !== e.irq) begin
        if (errors < 10)
          $display("response mismatch: read_data exp %h got %h, irq exp %b got %b",
                   e.read_data, got.read_data, e.irq, got.irq);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  int    idle_pct = 0;
  int    stall_pct = 0;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  int    cycles = 0;

  timer_shadow shadow = new();

  system_timer_compare_channels DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** system_timer_compare_channels: FAILED **");
      $finish;
    end
    if (!rst) begin
      if (req_valid && req_ready) shadow.take_request(req);
      if (rsp_valid && rsp_ready) shadow.match_response(rsp);
    end
  end

  // Response side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic req_t mk(logic [1:0] op, logic [7:0] a, logic [3:0] be, logic [31:0] d);
    req_t w;
    w.op = op;
    w.word_addr = a;
    w.byte_enable = be;
    w.write_data = d;
    return w;
  endfunction

  function automatic logic [7:0] chan_addr(int ch, logic [1:0] k);
    return 8'(CHAN_BASE + 4 * ch + k);
  endfunction

  task automatic send_word(req_t w);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // Mostly well-formed timer programming aimed near the live count, some noise.
  function automatic req_t next_word();
    int sel;
    int ch;
    logic [31:0] d;
    logic [3:0] be;
    sel = $urandom_range(99);
    ch = $urandom_range(NUM_CHANNELS - 1);
    d = $urandom;
    be = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'hF;
    if (sel < 50) return mk(OP_TICK, 8'($urandom), 4'($urandom), d);
    if (sel < 65) begin
      case ($urandom_range(4))
        0: return mk(OP_READ, ADDR_CTRL, 4'($urandom), d);
        1: return mk(OP_READ, ADDR_COUNT, 4'($urandom), d);
        2: return mk(OP_READ, 8'($urandom), 4'($urandom), d);
        default: return mk(OP_READ, chan_addr(ch, 2'($urandom_range(2))), 4'($urandom), d);
      endcase
    end
    if (sel < 97) begin
      case ($urandom_range(9))
        0: begin
          d[15:8] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
          d[0] = ($urandom_range(4) != 0);
          return mk(OP_WRITE, ADDR_CTRL, be, d);
        end
        1: begin
          case ($urandom_range(2))
            0: d = 32'hFFFF_FFF0 | 32'($urandom_range(15));
            1: d = shadow.counter - 32'($urandom_range(8));
            default: ;
          endcase
          return mk(OP_WRITE, ADDR_COUNT, be, d);
        end
        2, 3: begin
          if ($urandom_range(4) != 0) d = shadow.counter + 32'($urandom_range(1, 12));
          return mk(OP_WRITE, chan_addr(ch, REG_COMPARE), be, d);
        end
        4, 5: begin
          d[0] = ($urandom_range(3) != 0);
          if ($urandom_range(3) != 0) be[0] = 1'b1;
          return mk(OP_WRITE, chan_addr(ch, REG_ENABLE), be, d);
        end
        6, 7: begin
          d[0] = ($urandom_range(3) != 0);
          if ($urandom_range(3) != 0) be[0] = 1'b1;
          return mk(OP_WRITE, chan_addr(ch, REG_FLAG), be, d);
        end
        8: return mk(OP_WRITE, 8'($urandom), 4'($urandom), d);
        default: return mk(OP_WRITE, chan_addr(ch, REG_UNUSED), 4'($urandom), d);
      endcase
    end
    return mk(OP_UNUSED, 8'($urandom), 4'($urandom), d);
  endfunction

  task automatic run_phase(int idle, int stall, bit with_hold);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < WORDS_PER_PHASE; i++) begin
      if (with_hold && i == 60) hold_req = 1'b1;
      send_word(next_word());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, full control word, wrap onto compare 0, flag clear rules
    send_word(mk(OP_READ,  ADDR_CTRL, 4'h0, 32'h0));
    send_word(mk(OP_WRITE, ADDR_CTRL, 4'hF, 32'hFFFF_FFFF));
    send_word(mk(OP_READ,  ADDR_CTRL, 4'hF, 32'h0));
    send_word(mk(OP_WRITE, ADDR_CTRL, 4'h2, 32'h0));
    send_word(mk(OP_WRITE, ADDR_COUNT, 4'hF, 32'hFFFF_FFFE));
    send_word(mk(OP_WRITE, chan_addr(0, REG_COMPARE), 4'hF, 32'h0));
    send_word(mk(OP_WRITE, chan_addr(0, REG_ENABLE), 4'h1, 32'h1));
    send_word(mk(OP_WRITE, chan_addr(NUM_CHANNELS - 1, REG_ENABLE), 4'hE, 32'hFFFF_FFFF));
    send_word(mk(OP_TICK,  ADDR_CTRL, 4'h0, 32'h0));
    send_word(mk(OP_TICK,  ADDR_CTRL, 4'h0, 32'h0));
    send_word(mk(OP_READ,  chan_addr(0, REG_FLAG), 4'h0, 32'h0));
    send_word(mk(OP_WRITE, chan_addr(0, REG_FLAG), 4'hE, 32'hFFFF_FFFF));
    send_word(mk(OP_WRITE, chan_addr(0, REG_FLAG), 4'h1, 32'h0));
    send_word(mk(OP_WRITE, chan_addr(0, REG_FLAG), 4'h1, 32'h1));
    send_word(mk(OP_WRITE, ADDR_COUNT, 4'hF, 32'h0));
    send_word(mk(OP_WRITE, ADDR_CTRL, 4'h0, 32'h1));
    send_word(mk(OP_READ,  ADDR_GAP, 4'hF, 32'h0));
    send_word(mk(OP_READ,  chan_addr(0, REG_UNUSED), 4'hF, 32'h0));
    send_word(mk(OP_WRITE, chan_addr(NUM_CHANNELS, REG_ENABLE), 4'hF, 32'hFFFF_FFFF));
    send_word(mk(OP_READ,  ADDR_TOP, 4'hF, 32'h0));
    send_word(mk(OP_UNUSED, ADDR_TOP, 4'hF, 32'hFFFF_FFFF));
    send_word(mk(OP_WRITE, ADDR_CTRL, 4'hF, 32'h0000_0201));
    repeat (3) send_word(mk(OP_TICK, ADDR_CTRL, 4'h0, 32'h0));
    send_word(mk(OP_READ,  ADDR_COUNT, 4'hF, 32'h0));

    run_phase(0, 0, 1'b1);
    run_phase(76, 0, 1'b0);
    run_phase(0, 76, 1'b0);
    run_phase(38, 38, 1'b0);
    req_valid <= 1'b0;

    while (shadow.due_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.errors == 0 && shadow.due_rsp.size() == 0)
      $display("** system_timer_compare_channels: PASSED **");
    else
      $display("** system_timer_compare_channels: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/stc_pkg.sv
sv/stc_in_stage.sv
sv/stc_core.sv
sv/system_timer_compare_channels.sv
sim/tb_system_timer_compare_channels.sv
